### design/grmc_pkg.sv
package grmc_pkg;

   localparam int POS_W      = 20;
   localparam int STEP_W     = 14;
   localparam int BOX_W      = 13;
   localparam int CNT_W      = 16;
   localparam int ROWBITS_W  = 32;
   localparam int ROWIDX_W   = 4;
   localparam int TILE_SHIFT = 12;
   // signed tile index wide enough for floor(pos +/- box) plus one
   localparam int TIDX_W     = POS_W + 2 - TILE_SHIFT + 1;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CNT_W-1:0] STEP_LIMIT_RESET = 16'd2000;
   localparam logic [BOX_W-1:0] BOX_SIZE_RESET   = 13'd2048;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RAY  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_STEP_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_SIZE   = 1'b1;

   typedef struct packed {
      logic write_row;
      logic load_ray;
      logic advance;
      logic bounds;
      logic read_row;
      logic next_row;
      logic count;
      logic finish;
      logic hit;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic row_hit;
      logic row_last;
      logic at_limit;
   } dp_status_type;

endpackage

### design/grmc_datapath.sv
module grmc_datapath #(
   parameter int MAP_ROWS = 16,
   parameter int MAP_COLS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  grmc_pkg::ctl_cmd_type                 cmd,
   output grmc_pkg::dp_status_type               status,
   input  logic                                  csr_we,
   input  logic [grmc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [grmc_pkg::CSR_W-1:0]            csr_wdata,
   input  logic [grmc_pkg::ROWIDX_W-1:0]         req_row_index,
   input  logic [grmc_pkg::ROWBITS_W-1:0]        req_row_bits,
   input  logic signed [grmc_pkg::POS_W-1:0]     req_start_x,
   input  logic signed [grmc_pkg::POS_W-1:0]     req_start_y,
   input  logic signed [grmc_pkg::STEP_W-1:0]    req_step_x,
   input  logic signed [grmc_pkg::STEP_W-1:0]    req_step_y,
   output logic signed [grmc_pkg::POS_W-1:0]     rsp_end_x,
   output logic signed [grmc_pkg::POS_W-1:0]     rsp_end_y,
   output logic [grmc_pkg::CNT_W-1:0]            rsp_steps_taken,
   output logic                                  rsp_collided
);

   localparam int ROW_AW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam int PW     = grmc_pkg::POS_W;
   localparam int TW     = grmc_pkg::TIDX_W;
   localparam int SUM_W  = PW + 2;

   localparam logic signed [TW-1:0] COL_MAX = TW'(MAP_COLS - 1);
   localparam logic signed [TW-1:0] ROW_MAX = TW'(MAP_ROWS - 1);

   // tile map and per-row valid bits
   logic [MAP_COLS-1:0] map_mem [MAP_ROWS];
   logic [MAP_ROWS-1:0] row_vld_ff;
   logic [MAP_COLS-1:0] rd_data_ff;
   logic                rd_vld_ff;

   logic [grmc_pkg::CNT_W-1:0] limit_ff;
   logic [grmc_pkg::BOX_W-1:0] box_ff;

   logic signed [PW-1:0] pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic signed [grmc_pkg::STEP_W-1:0] stp_x_ff, stp_y_ff;
   logic [grmc_pkg::CNT_W-1:0] cnt_ff;

   logic [MAP_COLS-1:0] cols_ff, cols_in;
   logic [ROW_AW-1:0]   row_ff, ih_ff;
   logic                empty_ff, empty_in;

   logic signed [PW-1:0]         end_x_ff, end_y_ff;
   logic [grmc_pkg::CNT_W-1:0]   steps_ff;
   logic                         collided_ff;

   logic [6:0]  wr_idx;
   logic        wr_ok;
   logic [63:0] row_ext;

   logic signed [TW-1:0] jl, jh, il, ih, jl_c, jh_c, il_c, ih_c;

   // saturating add of one coordinate
   function automatic logic signed [PW-1:0] sat_add(
      input logic signed [PW-1:0]                  p,
      input logic signed [grmc_pkg::STEP_W-1:0]    d
   );
      logic signed [PW:0] sum;
      sum = {p[PW-1], p} + {{(PW + 1 - grmc_pkg::STEP_W){d[grmc_pkg::STEP_W-1]}}, d};
      if (sum[PW] != sum[PW-1]) begin
         sat_add = sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
      end else begin
         sat_add = sum[PW-1:0];
      end
   endfunction

   // floor(v / tile) of a widened sum, as a signed tile index
   function automatic logic signed [TW-1:0] tile_of(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] q;
      q = v >>> grmc_pkg::TILE_SHIFT;
      tile_of = TW'(q);
   endfunction

   function automatic logic signed [SUM_W-1:0] widen(input logic signed [PW-1:0] p);
      widen = {{2{p[PW-1]}}, p};
   endfunction

   assign pos_x_in = sat_add(pos_x_ff, stp_x_ff);
   assign pos_y_in = sat_add(pos_y_ff, stp_y_ff);

   // box edges in tiles, strict overlap
   always_comb begin
      logic signed [SUM_W-1:0] s;
      s  = SUM_W'(box_ff);
      jl = tile_of(widen(pos_x_ff) - s) + TW'(1);
      jh = tile_of(widen(pos_x_ff) + s - SUM_W'(1));
      il = tile_of(widen(pos_y_ff) - s) + TW'(1);
      ih = tile_of(widen(pos_y_ff) + s - SUM_W'(1));
      jl_c = (jl < 0) ? '0 : jl;
      jh_c = (jh > COL_MAX) ? COL_MAX : jh;
      il_c = (il < 0) ? '0 : il;
      ih_c = (ih > ROW_MAX) ? ROW_MAX : ih;
      empty_in = (jl_c > jh_c) || (il_c > ih_c);
      for (int k = 0; k < MAP_COLS; k++) begin
         cols_in[k] = (jl_c <= $signed(TW'(k))) && ($signed(TW'(k)) <= jh_c);
      end
   end

   // load address and row data fitted to the map
   assign wr_idx  = {3'b000, req_row_index};
   assign wr_ok   = wr_idx < 7'(MAP_ROWS);
   assign row_ext = {32'd0, req_row_bits};

   always_ff @(posedge clock) begin
      if (cmd.write_row && wr_ok) begin
         map_mem[wr_idx[ROW_AW-1:0]] <= row_ext[MAP_COLS-1:0];
      end
      if (cmd.read_row) begin
         rd_data_ff <= map_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         limit_ff   <= grmc_pkg::STEP_LIMIT_RESET;
         box_ff     <= grmc_pkg::BOX_SIZE_RESET;
         cnt_ff     <= '0;
      end else begin
         if (cmd.write_row && wr_ok) begin
            row_vld_ff[wr_idx[ROW_AW-1:0]] <= 1'b1;
         end
         if (cmd.read_row) begin
            rd_vld_ff <= row_vld_ff[row_ff];
         end
         if (csr_we) begin
            unique case (csr_index)
               grmc_pkg::REG_STEP_LIMIT: limit_ff <= csr_wdata;
               grmc_pkg::REG_BOX_SIZE:   box_ff   <= csr_wdata[grmc_pkg::BOX_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load_ray || cmd.finish) begin
            cnt_ff <= '0;
         end else if (cmd.count) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_ray) begin
         pos_x_ff <= req_start_x;
         pos_y_ff <= req_start_y;
         stp_x_ff <= req_step_x;
         stp_y_ff <= req_step_y;
      end else if (cmd.advance) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
      if (cmd.bounds) begin
         cols_ff  <= cols_in;
         empty_ff <= empty_in;
         row_ff   <= il_c[ROW_AW-1:0];
         ih_ff    <= ih_c[ROW_AW-1:0];
      end else if (cmd.next_row) begin
         row_ff <= row_ff + ROW_AW'(1);
      end
      if (cmd.finish) begin
         end_x_ff    <= pos_x_ff;
         end_y_ff    <= pos_y_ff;
         steps_ff    <= (&cnt_ff) ? cnt_ff : cnt_ff + 1'b1;
         collided_ff <= cmd.hit;
      end
   end

   assign status.empty    = empty_ff;
   assign status.row_hit  = rd_vld_ff && (|(rd_data_ff & cols_ff));
   assign status.row_last = (row_ff == ih_ff);
   assign status.at_limit = (cnt_ff >= limit_ff);

   assign rsp_end_x       = end_x_ff;
   assign rsp_end_y       = end_y_ff;
   assign rsp_steps_taken = steps_ff;
   assign rsp_collided    = collided_ff;

endmodule

### design/grmc_ctrl.sv
module grmc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_cmd,
   input  grmc_pkg::dp_status_type status,
   output grmc_pkg::ctl_cmd_type   cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_BOUNDS,
      ST_READ,
      ST_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      accept;
   logic      step_clear;

   assign accept = start && (state_ff == ST_IDLE);

   // step ends without a hit: either the box misses the map or the last row was clear
   assign step_clear = ((state_ff == ST_READ) && status.empty) ||
                       ((state_ff == ST_CHECK) && !status.row_hit && status.row_last);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == grmc_pkg::CMD_RAY) begin
                  cmd.load_ray = 1'b1;
                  state_in     = ST_ADVANCE;
               end else begin
                  cmd.write_row = 1'b1;
               end
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_BOUNDS;
         end
         ST_BOUNDS: begin
            cmd.bounds = 1'b1;
            state_in   = ST_READ;
         end
         ST_READ: begin
            if (!status.empty) begin
               cmd.read_row = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.row_hit) begin
               cmd.finish = 1'b1;
               cmd.hit    = 1'b1;
               state_in   = ST_IDLE;
            end else if (!status.row_last) begin
               cmd.next_row = 1'b1;
               state_in     = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (step_clear) begin
         if (status.at_limit) begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end else begin
            cmd.count = 1'b1;
            state_in  = ST_ADVANCE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/grid_ray_march_collision.sv
// Sequence: a load item writes its row in the accept cycle. A ray item makes N advances, where N
//   is at most step_limit + 1, and after each one reads the R map rows under the box in turn up to
//   a hit (R is 1 to 4, 0 if the box misses the map); the result shows in the next cycle.
// Throughput: one item at a time; the single read port of the tile map sets the per-step cost.
// Reset: synchronous, active high; invalidates every map row, clears the step counter and the controller,
//   and restores step_limit to 2000 and box_size to 2048. The receiver cannot stall.
module grid_ray_march_collision #(
   parameter int MAP_ROWS = 16,
   parameter int MAP_COLS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // item input
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_cmd,
   input  logic [grmc_pkg::ROWIDX_W-1:0]         req_row_index,
   input  logic [grmc_pkg::ROWBITS_W-1:0]        req_row_bits,
   input  logic signed [grmc_pkg::POS_W-1:0]     req_start_x,
   input  logic signed [grmc_pkg::POS_W-1:0]     req_start_y,
   input  logic signed [grmc_pkg::STEP_W-1:0]    req_step_x,
   input  logic signed [grmc_pkg::STEP_W-1:0]    req_step_y,
   // result output, one-cycle strobe
   output logic                                  rsp_valid,
   output logic signed [grmc_pkg::POS_W-1:0]     rsp_end_x,
   output logic signed [grmc_pkg::POS_W-1:0]     rsp_end_y,
   output logic [grmc_pkg::CNT_W-1:0]            rsp_steps_taken,
   output logic                                  rsp_collided,
   // register writes
   input  logic                                  csr_we,
   input  logic [grmc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [grmc_pkg::CSR_W-1:0]            csr_wdata
);

   // command and status between controller and datapath
   grmc_pkg::ctl_cmd_type   cmd;
   grmc_pkg::dp_status_type status;

   // The controller sequences each step: advance the point, register the box
   // bounds in tiles, then read and test each covered map row in turn.
   // Stop on the first solid overlap or once the count reaches step_limit.
   grmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the map, the registers, the ray point and the counter.
   // Load items write a row in the accept cycle; rows beyond the map are dropped.
   grmc_datapath #(
      .MAP_ROWS (MAP_ROWS),
      .MAP_COLS (MAP_COLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_row_index   (req_row_index),
      .req_row_bits    (req_row_bits),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_step_x      (req_step_x),
      .req_step_y      (req_step_y),
      .rsp_end_x       (rsp_end_x),
      .rsp_end_y       (rsp_end_y),
      .rsp_steps_taken (rsp_steps_taken),
      .rsp_collided    (rsp_collided)
   );

endmodule

### tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import grmc_pkg::*;

   // Map shape as built (default parameters of the block).
   localparam int MAP_H = 16;
   localparam int MAP_W = 32;
   localparam int TILE = 1 << TILE_SHIFT;
   localparam int POS_HI = (1 << (POS_W - 1)) - 1;
   localparam int POS_LO = -(1 << (POS_W - 1));

   // Idle cycles required before a register write or a drain point is passed.
   localparam int SETTLE_CYCLES = 4;
   // Cycles watched after the last result for a stray one.
   localparam int TAIL_CYCLES = 64;
   // Watchdog bound on the whole run, well above the slowest correct run.
   localparam int CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic                       cmd;
      logic [ROWIDX_W-1:0]        row_index;
      logic [ROWBITS_W-1:0]       row_bits;
      logic signed [POS_W-1:0]    start_x;
      logic signed [POS_W-1:0]    start_y;
      logic signed [STEP_W-1:0]   step_x;
      logic signed [STEP_W-1:0]   step_y;
   } ray_item_t;

   typedef struct packed {
      logic signed [POS_W-1:0]    end_x;
      logic signed [POS_W-1:0]    end_y;
      logic [CNT_W-1:0]           steps;
      logic                       collided;
   } stop_t;

   // What the driver does next: send an item, write a register, wait for the
   // block to go quiet, or change how often the sender holds back.
   typedef enum logic [1:0] {BL_ITEM, BL_CSR, BL_DRAIN, BL_GAP} backlog_kind_t;

   typedef struct packed {
      backlog_kind_t              kind;
      ray_item_t                  item;
      logic [CSR_IDX_W-1:0]       csr_idx;
      logic [CSR_W-1:0]           csr_data;
      logic [7:0]                 gap_pct;
   } backlog_entry_t;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_cmd = CMD_LOAD;
   logic [ROWIDX_W-1:0]           req_row_index = '0;
   logic [ROWBITS_W-1:0]          req_row_bits = '0;
   logic signed [POS_W-1:0]       req_start_x = '0;
   logic signed [POS_W-1:0]       req_start_y = '0;
   logic signed [STEP_W-1:0]      req_step_x = '0;
   logic signed [STEP_W-1:0]      req_step_y = '0;
   logic                          rsp_valid;
   logic signed [POS_W-1:0]       rsp_end_x;
   logic signed [POS_W-1:0]       rsp_end_y;
   logic [CNT_W-1:0]              rsp_steps_taken;
   logic                          rsp_collided;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = REG_STEP_LIMIT;
   logic [CSR_W-1:0]              csr_wdata = '0;

   // Shadow of the block: map rows and the two registers.
   logic [ROWBITS_W-1:0]          map_rows [MAP_H];
   logic [CNT_W-1:0]              march_limit = STEP_LIMIT_RESET;
   logic [BOX_W-1:0]              box_half = BOX_SIZE_RESET;

   backlog_entry_t                cmd_backlog [$];
   stop_t                         predicted_stops [$];
   ray_item_t                     on_ports;
   int                            sender_gap_pct = 0;
   int unsigned                   quiet_cycles = 0;
   int unsigned                   mismatch_count = 0;
   int unsigned                   cycle_count = 0;

   grid_ray_march_collision DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_row_index   (req_row_index),
      .req_row_bits    (req_row_bits),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_step_x      (req_step_x),
      .req_step_y      (req_step_y),
      .rsp_valid       (rsp_valid),
      .rsp_end_x       (rsp_end_x),
      .rsp_end_y       (rsp_end_y),
      .rsp_steps_taken (rsp_steps_taken),
      .rsp_collided    (rsp_collided),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic longint clamp_pos(longint v);
      if (v > POS_HI)
         return POS_HI;
      if (v < POS_LO)
         return POS_LO;
      return v;
   endfunction

   // Strict overlap of the box centred on (px, py) with any solid tile.
   // Arithmetic shift gives floor division by one tile; tiles past the map
   // edges are clear, so clip the tile window to the map.
   function automatic bit box_touches_wall(longint px, longint py, longint half);
      longint     col_lo;
      longint     col_hi;
      longint     row_lo;
      longint     row_hi;
      logic [63:0] cols;
      bit         touched;
      col_lo = ((px - half) >>> TILE_SHIFT) + 1;
      col_hi = (px + half - 1) >>> TILE_SHIFT;
      row_lo = ((py - half) >>> TILE_SHIFT) + 1;
      row_hi = (py + half - 1) >>> TILE_SHIFT;
      if (col_lo < 0)
         col_lo = 0;
      if (col_hi > MAP_W - 1)
         col_hi = MAP_W - 1;
      if (row_lo < 0)
         row_lo = 0;
      if (row_hi > MAP_H - 1)
         row_hi = MAP_H - 1;
      touched = 1'b0;
      if (col_lo <= col_hi && row_lo <= row_hi) begin
         cols = (64'd2 << col_hi) - (64'd1 << col_lo);
         for (longint r = row_lo; r <= row_hi; r++) begin
            if ((map_rows[r] & cols[ROWBITS_W-1:0]) != '0)
               touched = 1'b1;
         end
      end
      return touched;
   endfunction

   // Advance by fixed steps, test the box after every advance, and stop on a
   // hit or once the advances counted before this one reach the limit.
   function automatic stop_t march_ray(ray_item_t it);
      longint      x;
      longint      y;
      longint      dx;
      longint      dy;
      int unsigned counted;
      int unsigned advances;
      bit          hit;
      bit          done;
      stop_t       s;
      x = it.start_x;
      y = it.start_y;
      dx = it.step_x;
      dy = it.step_y;
      counted = 0;
      advances = 0;
      hit = 1'b0;
      done = 1'b0;
      while (!done) begin
         x = clamp_pos(x + dx);
         y = clamp_pos(y + dy);
         advances++;
         hit = box_touches_wall(x, y, longint'(box_half));
         if (hit || counted >= march_limit)
            done = 1'b1;
         else
            counted++;
      end
      s.end_x = POS_W'(x);
      s.end_y = POS_W'(y);
      // 65536 advances do not fit the count field: saturate
      s.steps = (advances > 32'hFFFF) ? '1 : CNT_W'(advances);
      s.collided = hit;
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------

   function automatic ray_item_t make_ray(int x, int y, int dx, int dy);
      ray_item_t it;
      it.cmd = CMD_RAY;
      // row fields are don't-care for a ray: fill them anyway
      it.row_index = ROWIDX_W'($urandom);
      it.row_bits = $urandom;
      it.start_x = POS_W'(x);
      it.start_y = POS_W'(y);
      it.step_x = STEP_W'(dx);
      it.step_y = STEP_W'(dy);
      return it;
   endfunction

   function automatic ray_item_t make_load(int row, logic [ROWBITS_W-1:0] bits);
      ray_item_t it;
      it = make_ray(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
      it.cmd = CMD_LOAD;
      it.row_index = ROWIDX_W'(row);
      it.row_bits = bits;
      return it;
   endfunction

   function automatic logic [ROWBITS_W-1:0] random_row_bits();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return $urandom;
         default: return $urandom & $urandom & $urandom;
      endcase
   endfunction

   function automatic ray_item_t random_ray();
      ray_item_t   it;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         // start in or near the map, where the walls are
         it = make_ray(int'($urandom_range(0, 40 * TILE)) - 4 * TILE,
                       int'($urandom_range(0, 24 * TILE)) - 4 * TILE, 0, 0);
         if ($urandom_range(0, 3) == 0) begin
            it.step_x = STEP_W'(int'($urandom_range(0, 1024)) - 512);
            it.step_y = STEP_W'(int'($urandom_range(0, 1024)) - 512);
         end else begin
            it.step_x = STEP_W'(int'($urandom_range(0, 2 * TILE)) - TILE);
            it.step_y = STEP_W'(int'($urandom_range(0, 2 * TILE)) - TILE);
         end
      end else if (pick < 85) begin
         // anything the field widths allow, raw out-of-range steps included
         it = make_ray(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
      end else begin
         // hug the saturation edges
         it = make_ray(($urandom_range(0, 1) == 1) ?
                          POS_HI - int'($urandom_range(0, 2 * TILE)) :
                          POS_LO + int'($urandom_range(0, 2 * TILE)),
                       ($urandom_range(0, 1) == 1) ?
                          POS_HI - int'($urandom_range(0, 2 * TILE)) :
                          POS_LO + int'($urandom_range(0, 2 * TILE)),
                       int'($urandom), int'($urandom));
      end
      return it;
   endfunction

   function automatic void queue_item(ray_item_t it);
      backlog_entry_t e;
      e = '0;
      e.kind = BL_ITEM;
      e.item = it;
      cmd_backlog.push_back(e);
   endfunction

   function automatic void queue_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      backlog_entry_t e;
      e = '0;
      e.kind = BL_CSR;
      e.csr_idx = idx;
      e.csr_data = data;
      cmd_backlog.push_back(e);
   endfunction

   function automatic void queue_marker(backlog_kind_t kind, int pct);
      backlog_entry_t e;
      e = '0;
      e.kind = kind;
      e.gap_pct = 8'(pct);
      cmd_backlog.push_back(e);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one nonblocking update per signal per edge, computed first
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_items
      logic           nxt_start;
      logic           nxt_we;
      backlog_entry_t head;
      nxt_start = start;
      nxt_we = 1'b0;
      if (reset) begin
         nxt_start = 1'b0;
         quiet_cycles = 0;
         march_limit = STEP_LIMIT_RESET;
         box_half = BOX_SIZE_RESET;
         for (int r = 0; r < MAP_H; r++)
            map_rows[r] = '0;
      end else begin
         // a register write lands at this edge
         if (csr_we) begin
            if (csr_index == REG_STEP_LIMIT)
               march_limit = csr_wdata[CNT_W-1:0];
            else if (csr_index == REG_BOX_SIZE)
               box_half = csr_wdata[BOX_W-1:0];
         end
         // item accepted: update the map or predict the stop point
         if (start && busy === 1'b0) begin
            if (on_ports.cmd == CMD_RAY)
               predicted_stops.push_back(march_ray(on_ports));
            else
               map_rows[on_ports.row_index] = on_ports.row_bits;
            nxt_start = 1'b0;
         end
         // count cycles with nothing in flight; loads give no result, so
         // hold register writes off until the block has sat idle a while
         if (!start && !csr_we && busy === 1'b0 && predicted_stops.size() == 0)
            quiet_cycles++;
         else
            quiet_cycles = 0;
         if (!nxt_start && cmd_backlog.size() != 0) begin
            head = cmd_backlog[0];
            case (head.kind)
               BL_GAP: begin
                  sender_gap_pct = int'(head.gap_pct);
                  void'(cmd_backlog.pop_front());
               end
               BL_DRAIN: begin
                  if (quiet_cycles >= SETTLE_CYCLES)
                     void'(cmd_backlog.pop_front());
               end
               BL_CSR: begin
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     nxt_we = 1'b1;
                     csr_index <= head.csr_idx;
                     csr_wdata <= head.csr_data;
                     void'(cmd_backlog.pop_front());
                  end
               end
               default: begin
                  // hold back at random, otherwise present the next item
                  if (int'($urandom_range(0, 99)) >= sender_gap_pct) begin
                     nxt_start = 1'b1;
                     on_ports = head.item;
                     req_cmd <= head.item.cmd;
                     req_row_index <= head.item.row_index;
                     req_row_bits <= head.item.row_bits;
                     req_start_x <= head.item.start_x;
                     req_start_y <= head.item.start_y;
                     req_step_x <= head.item.step_x;
                     req_step_y <= head.item.step_y;
                     void'(cmd_backlog.pop_front());
                  end
               end
            endcase
         end
      end
      start <= nxt_start;
      csr_we <= nxt_we;
   end

   // ---------------------------------------------------------------------
   // Monitor: results are one-cycle strobes, compare against oldest prediction
   // ---------------------------------------------------------------------
   task automatic flag_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_stops
      stop_t want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (predicted_stops.size() == 0) begin
            $display("%0t ns: result expected none actual end (%0d, %0d) steps %0d hit %0b",
                     $time, rsp_end_x, rsp_end_y, rsp_steps_taken, rsp_collided);
            mismatch_count++;
         end else begin
            want = predicted_stops.pop_front();
            if (rsp_end_x !== want.end_x)
               flag_field("end_x", want.end_x, rsp_end_x);
            if (rsp_end_y !== want.end_y)
               flag_field("end_y", want.end_y, rsp_end_y);
            if (rsp_steps_taken !== want.steps)
               flag_field("steps_taken", want.steps, rsp_steps_taken);
            if (rsp_collided !== want.collided)
               flag_field("collided", want.collided, rsp_collided);
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout, %0d results still pending", $time, predicted_stops.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : run_stimulus
      int lim;
      int box;
      // directed part, reset settings (limit 2000, half box 0.5 tile)
      queue_marker(BL_GAP, 27);
      queue_item(make_load(0, 32'hFFFF_FFFF));   // top row solid, both edge columns
      queue_item(make_load(15, 32'h8000_0001));  // bottom row, first and last column
      queue_item(make_load(6, 32'h0000_0400));   // single wall at column 10
      queue_item(make_load(9, 32'h0001_0000));   // single wall at column 16
      queue_item(make_ray(2 * TILE, 6 * TILE, TILE, 0));       // east into column 10
      queue_item(make_ray(5 * TILE, 8 * TILE, 0, -TILE));      // north into the top row
      queue_item(make_ray(3 * TILE, 0, 0, 0));                 // parked in a wall
      queue_item(make_ray(20 * TILE, 12 * TILE, 0, 0));        // parked in the open
      queue_item(make_ray(POS_HI, POS_HI, -TILE, -TILE));      // from the top corner inward
      queue_item(make_ray(POS_LO, POS_LO, -TILE, -TILE));      // pinned at the low corner
      queue_item(make_ray(16 * TILE, 8 * TILE, 8191, -8192));  // raw steps past one tile
      queue_item(make_ray(0, 20 * TILE, TILE, 0));             // below the map: all clear
      // zero box: strict overlap never hits, even inside a wall
      queue_csr(REG_BOX_SIZE, '0);
      queue_item(make_ray(3 * TILE, 0, 0, 0));
      // limit zero: one advance; a hit on that advance still reports collided
      queue_csr(REG_STEP_LIMIT, '0);
      queue_csr(REG_BOX_SIZE, CSR_W'(TILE / 2));
      queue_item(make_ray(3 * TILE, TILE, 0, -TILE));
      queue_item(make_ray(20 * TILE, 12 * TILE, TILE, 0));
      // widest limit: with the box off the map the count saturates
      queue_csr(REG_BOX_SIZE, CSR_W'(TILE));
      queue_csr(REG_STEP_LIMIT, '1);
      queue_item(make_ray(POS_LO, POS_LO, 0, 0));
      queue_item(make_ray(10 * TILE, 2 * TILE, 0, TILE));
      // all-ones write: upper bits of the box field drop
      queue_csr(REG_STEP_LIMIT, CSR_W'(5));
      queue_csr(REG_BOX_SIZE, '1);
      queue_item(make_ray(12 * TILE, 12 * TILE, -TILE, -TILE));
      queue_item(make_ray(28 * TILE, 3 * TILE, TILE, 0));

      // random part: three sender idling modes, three settings each;
      // every block reloads some rows before casting rays through them
      for (int phase = 0; phase < 3; phase++) begin
         queue_marker(BL_GAP, (phase == 0) ? 27 : (phase == 1) ? 62 : 0);
         for (int blk = 0; blk < 3; blk++) begin
            case ($urandom_range(0, 9))
               0: lim = 0;
               1: lim = 1;
               default: lim = int'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 5))
               0: box = 0;
               1: box = TILE;
               2: box = int'($urandom_range(0, 65535));
               default: box = int'($urandom_range(256, TILE));
            endcase
            queue_csr(REG_STEP_LIMIT, CSR_W'(lim));
            queue_csr(REG_BOX_SIZE, CSR_W'(box));
            for (int n = 0; n < 30; n++) begin
               if (n < 4 || $urandom_range(0, 99) < 15)
                  queue_item(make_load(int'($urandom_range(0, MAP_H - 1)), random_row_bits()));
               else
                  queue_item(random_ray());
            end
            // hold the sender until every pending result is back
            if (blk == 1)
               queue_marker(BL_DRAIN, 0);
         end
      end

      while (reset)
         @(negedge clock);
      // sample between edges so the driver's updates have settled
      while (cmd_backlog.size() != 0 || start || csr_we || busy !== 1'b0 ||
             predicted_stops.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### grid_ray_march_collision.f
design/grmc_pkg.sv
design/grmc_datapath.sv
design/grmc_ctrl.sv
design/grid_ray_march_collision.sv
tb/tb_top.sv
